/* hw/rtl/fcr_pkg.sv */
// Shared types, codes and register layout constants of the flash controller register block.
package fcr_pkg;

    localparam int PAGE_BITS       = 7;
    localparam int FLASH_ADDR_BITS = 20;
    localparam int TICK_BITS       = 16;

    localparam logic [TICK_BITS-1:0] BUSY_TICKS_RESET = 16'd16;

    localparam logic [31:0] KEY_FIRST  = 32'h4567_0123;
    localparam logic [31:0] KEY_SECOND = 32'hCDEF_89AB;

    localparam logic [7:0] OFS_LATENCY = 8'h00;
    localparam logic [7:0] OFS_KEY     = 8'h08;
    localparam logic [7:0] OFS_STATUS  = 8'h20;
    localparam logic [7:0] OFS_CONTROL = 8'h28;

    // Status register bit positions
    localparam int ST_EOP     = 0;
    localparam int ST_OPERR   = 1;
    localparam int ST_PROGERR = 3;
    localparam int ST_WRPERR  = 4;
    localparam int ST_PGAERR  = 5;
    localparam int ST_SIZERR  = 6;
    localparam int ST_PGSERR  = 7;
    localparam int ST_OPTWERR = 13;
    localparam int ST_BSY     = 16;

    // Control register bit positions
    localparam int CR_PG   = 0;
    localparam int CR_PER  = 1;
    localparam int CR_MER  = 2;
    localparam int CR_PNB  = 3;
    localparam int CR_BWR  = 14;
    localparam int CR_STRT = 16;
    localparam int CR_LOCK = 31;

    // Index of two flags in the error flag word, and the word's width
    localparam int ERR_PGAERR = 3;
    localparam int ERR_PGSERR = 5;
    localparam int ERR_COUNT  = 7;

    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_TICK    = 2'd2,
        MODE_PROGRAM = 2'd3
    } fcr_mode_t;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [7:0]                 reg_offset;
        logic [31:0]                write_data;
        logic [FLASH_ADDR_BITS-1:0] flash_offset;
    } fcr_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        busy_res;
        logic        any_error;
    } fcr_out_t;

endpackage

/* hw/rtl/fcr_core.sv */
// Register state and single-pass update logic of the flash controller register block.
module fcr_core
    import fcr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  fcr_in_t              item,
    input  logic [TICK_BITS-1:0] busy_ticks,
    output fcr_out_t             result
);

    logic                 locked_reg, locked_next;
    logic                 key_stage_reg, key_stage_next;
    logic [3:0]           wait_states_reg, wait_states_next;
    logic                 pg_reg, pg_next;
    logic                 per_reg, per_next;
    logic                 mer_reg, mer_next;
    logic                 bwr_reg, bwr_next;
    logic                 strt_reg, strt_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [ERR_COUNT-1:0] err_reg, err_next;
    logic                 eop_reg, eop_next;
    logic [TICK_BITS-1:0] busy_reg, busy_next;

    logic                 busy_now;
    logic [TICK_BITS-1:0] busy_load;
    logic [ERR_COUNT-1:0] err_clear;
    logic [31:0]          status_view;
    logic [31:0]          control_view;
    logic [31:0]          read_value;
    logic                 prog_bad;

    assign busy_now  = (busy_reg != '0);
    assign busy_load = (busy_ticks == '0) ? TICK_BITS'(1) : busy_ticks;

    always_comb begin
        status_view                = '0;
        status_view[ST_EOP]        = eop_reg;
        status_view[ST_OPERR]      = err_reg[0];
        status_view[ST_PROGERR]    = err_reg[1];
        status_view[ST_WRPERR]     = err_reg[2];
        status_view[ST_PGAERR]     = err_reg[3];
        status_view[ST_SIZERR]     = err_reg[4];
        status_view[ST_PGSERR]     = err_reg[5];
        status_view[ST_OPTWERR]    = err_reg[6];
        status_view[ST_BSY]        = busy_now;

        control_view                          = '0;
        control_view[CR_PG]                   = pg_reg;
        control_view[CR_PER]                  = per_reg;
        control_view[CR_MER]                  = mer_reg;
        control_view[CR_PNB +: PAGE_BITS]     = page_reg;
        control_view[CR_BWR]                  = bwr_reg;
        control_view[CR_STRT]                 = strt_reg;
        control_view[CR_LOCK]                 = locked_reg;
    end

    // Write-one-to-clear mask for the error flags
    assign err_clear = {item.write_data[ST_OPTWERR], item.write_data[ST_PGSERR],
                        item.write_data[ST_SIZERR],  item.write_data[ST_PGAERR],
                        item.write_data[ST_WRPERR],  item.write_data[ST_PROGERR],
                        item.write_data[ST_OPERR]};

    always_comb begin
        locked_next      = locked_reg;
        key_stage_next   = key_stage_reg;
        wait_states_next = wait_states_reg;
        pg_next          = pg_reg;
        per_next         = per_reg;
        mer_next         = mer_reg;
        bwr_next         = bwr_reg;
        strt_next        = strt_reg;
        page_next        = page_reg;
        err_next         = err_reg;
        eop_next         = eop_reg;
        busy_next        = busy_reg;
        read_value       = '0;
        prog_bad         = 1'b0;

        unique case (fcr_mode_t'(item.mode))
            MODE_READ: begin
                unique case (item.reg_offset)
                    OFS_LATENCY: read_value = {28'd0, wait_states_reg};
                    OFS_STATUS:  read_value = status_view;
                    OFS_CONTROL: read_value = control_view;
                    default:     read_value = '0;
                endcase
            end
            MODE_WRITE: begin
                unique case (item.reg_offset)
                    OFS_LATENCY: wait_states_next = item.write_data[3:0];
                    OFS_KEY: begin
                        if (locked_reg) begin
                            if (!key_stage_reg && item.write_data == KEY_FIRST) begin
                                key_stage_next = 1'b1;
                            end else if (key_stage_reg && item.write_data == KEY_SECOND) begin
                                locked_next    = 1'b0;
                                key_stage_next = 1'b0;
                            end else begin
                                key_stage_next = 1'b0;
                            end
                        end
                    end
                    OFS_STATUS: begin
                        if (item.write_data[ST_EOP]) begin
                            eop_next = 1'b0;
                        end
                        err_next = err_reg & ~err_clear;
                    end
                    OFS_CONTROL: begin
                        if (!locked_reg && !busy_now) begin
                            pg_next   = item.write_data[CR_PG];
                            per_next  = item.write_data[CR_PER];
                            mer_next  = item.write_data[CR_MER];
                            bwr_next  = item.write_data[CR_BWR];
                            page_next = item.write_data[CR_PNB +: PAGE_BITS];
                            strt_next = 1'b0;
                            if (item.write_data[CR_STRT]) begin
                                if (item.write_data[CR_PER] || item.write_data[CR_MER]) begin
                                    strt_next = 1'b1;
                                    busy_next = busy_load;
                                end else begin
                                    err_next[ERR_PGSERR] = 1'b1;
                                end
                            end
                            if (item.write_data[CR_LOCK]) begin
                                locked_next    = 1'b1;
                                key_stage_next = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_TICK: begin
                if (busy_now) begin
                    busy_next = busy_reg - TICK_BITS'(1);
                    if (busy_reg == TICK_BITS'(1)) begin
                        eop_next  = 1'b1;
                        strt_next = 1'b0;
                    end
                end
            end
            MODE_PROGRAM: begin
                if (!busy_now) begin
                    if (!pg_reg) begin
                        err_next[ERR_PGSERR] = 1'b1;
                        prog_bad             = 1'b1;
                    end
                    if (item.flash_offset[3:0] != 4'd0) begin
                        err_next[ERR_PGAERR] = 1'b1;
                        prog_bad             = 1'b1;
                    end
                    if (!prog_bad) begin
                        busy_next = busy_load;
                    end
                end
            end
            default: ;
        endcase
    end

    assign result.read_data = read_value;
    assign result.busy_res  = (busy_next != '0);
    assign result.any_error = (err_next != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg      <= 1'b1;
            key_stage_reg   <= 1'b0;
            wait_states_reg <= '0;
            pg_reg          <= 1'b0;
            per_reg         <= 1'b0;
            mer_reg         <= 1'b0;
            bwr_reg         <= 1'b0;
            strt_reg        <= 1'b0;
            page_reg        <= '0;
            err_reg         <= '0;
            eop_reg         <= 1'b0;
            busy_reg        <= '0;
        end else if (advance) begin
            locked_reg      <= locked_next;
            key_stage_reg   <= key_stage_next;
            wait_states_reg <= wait_states_next;
            pg_reg          <= pg_next;
            per_reg         <= per_next;
            mer_reg         <= mer_next;
            bwr_reg         <= bwr_next;
            strt_reg        <= strt_next;
            page_reg        <= page_next;
            err_reg         <= err_next;
            eop_reg         <= eop_next;
            busy_reg        <= busy_next;
        end
    end

    // Start only stands while an operation is counting down
    a_strt_means_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        strt_reg |-> busy_now)
        else $error("start bit set while not busy");

    // A pending first key only exists while locked
    a_key_stage_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        key_stage_reg |-> locked_reg)
        else $error("key stage advanced while unlocked");

    // The last tick of an operation raises end-of-operation
    a_last_tick_eop: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.mode == MODE_TICK && busy_reg == TICK_BITS'(1)) |=>
            (eop_reg && busy_reg == '0))
        else $error("operation ended without end-of-operation");

endmodule

/* hw/rtl/flash_controller_registers.sv */
// Top level of the flash controller register block: input register, core and result register.
// Pipeline: an accepted item is held in the input register, updates the core registers
//   as it advances, and its result is then held in the result register and shown on m_valid.
// Throughput: one item per cycle; the pipe stalls only when the result register is full
//   and m_ready is low, and accepts into the input register as the result drains.
// Reset: aresetn is synchronous and active low; it locks the block, clears all flags,
//   counters and both stage valids, and sets the busy tick count back to 16.
module flash_controller_registers
    import fcr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  fcr_in_t              s_payload,

    output logic                 m_valid,
    input  logic                 m_ready,
    output fcr_out_t             m_payload,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TICK_BITS-1:0] cfg_data
);

    logic                 in_valid_reg;
    fcr_in_t              in_item_reg;
    logic                 out_valid_reg;
    fcr_out_t             out_item_reg;
    logic [TICK_BITS-1:0] busy_ticks_reg;

    logic                 advance;
    fcr_out_t             core_result;

    // Advance the held item whenever the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    // Take a new busy tick count only once both stages have drained
    assign cfg_ready = !in_valid_reg && !out_valid_reg;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

    // Busy tick count register; written only while the pipe is empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_ticks_reg <= BUSY_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            busy_ticks_reg <= cfg_data;
        end
    end

    // Input register: capture a new item as the previous one moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
    end

    fcr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item       (in_item_reg),
        .busy_ticks (busy_ticks_reg),
        .result     (core_result)
    );

    // Result register: hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= core_result;
        end
    end

    // A held item must move on once the result side is free
    a_no_stall_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("item held although result register was free");

    // Drop no result: a full, unread result register blocks the core
    a_hold_unread_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("result overwritten before it was taken");

    // Hold a waiting result steady until it is taken
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("waiting result changed before it was taken");

endmodule

/* verif/flash_controller_registers_tb.sv */
// Self-checking testbench of the flash controller register block.
`timescale 1ns / 1ps

module flash_controller_registers_tb;
    import fcr_pkg::*;

    // Error flag word indexes that the package leaves unnamed
    localparam int ERR_OPERR   = 0;
    localparam int ERR_PROGERR = 1;
    localparam int ERR_WRPERR  = 2;
    localparam int ERR_SIZERR  = 4;
    localparam int ERR_OPTWERR = 6;

    localparam int unsigned LIMIT_CYCLES   = 300000;
    localparam int unsigned PHASE_ITEMS    = 95;
    localparam int unsigned PRESSURE_AFTER = 80;
    localparam int unsigned PRESSURE_HOLD  = 300;

    // One row of the directed table: an item, how often to offer it, and
    // optionally the result typed in by hand.
    typedef struct packed {
        fcr_in_t  item;
        logic [4:0] reps;
        logic     fixed;
        fcr_out_t res;
    } step_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    fcr_in_t              s_payload;
    logic                 m_valid;
    logic                 m_ready;
    fcr_out_t             m_payload;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TICK_BITS-1:0] cfg_data;

    // Side information travelling with the offered item
    logic     drv_fixed;
    fcr_out_t drv_fixed_res;

    fcr_out_t    awaited_results[$];
    step_row_t   step_table[$];
    int unsigned n_offered  = 0;
    int unsigned n_accepted = 0;
    int unsigned n_fail     = 0;
    int unsigned n_cycles   = 0;
    bit          calm       = 1'b0;

    // Mirror of the block's registers, advanced once per accepted item
    logic [TICK_BITS-1:0] busy_ticks = BUSY_TICKS_RESET;
    logic                 lock_q     = 1'b1;
    logic                 key_armed  = 1'b0;
    logic [3:0]           lat_ws     = '0;
    logic                 pg_en      = 1'b0;
    logic                 per_en     = 1'b0;
    logic                 mer_en     = 1'b0;
    logic                 bwr_en     = 1'b0;
    logic                 strt_en    = 1'b0;
    logic [PAGE_BITS-1:0] pnb        = '0;
    logic [ERR_COUNT-1:0] err_flags  = '0;
    logic                 eop        = 1'b0;
    logic [TICK_BITS-1:0] busy_left  = '0;

    flash_controller_registers dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) n_cycles <= n_cycles + 1;

    // A zero setting still holds busy for one tick.
    function automatic void load_busy();
        busy_left = (busy_ticks == '0) ? TICK_BITS'(1) : busy_ticks;
    endfunction

    // Advance the register mirror by one item and return the result it gives.
    function automatic fcr_out_t apply_item(input fcr_in_t it);
        fcr_out_t    r;
        logic [31:0] d;
        logic        bad;
        r = '0;
        d = it.write_data;
        case (fcr_mode_t'(it.mode))
            MODE_READ: begin
                case (it.reg_offset)
                    OFS_LATENCY: r.read_data[3:0] = lat_ws;
                    OFS_STATUS: begin
                        r.read_data[ST_EOP]     = eop;
                        r.read_data[ST_OPERR]   = err_flags[ERR_OPERR];
                        r.read_data[ST_PROGERR] = err_flags[ERR_PROGERR];
                        r.read_data[ST_WRPERR]  = err_flags[ERR_WRPERR];
                        r.read_data[ST_PGAERR]  = err_flags[ERR_PGAERR];
                        r.read_data[ST_SIZERR]  = err_flags[ERR_SIZERR];
                        r.read_data[ST_PGSERR]  = err_flags[ERR_PGSERR];
                        r.read_data[ST_OPTWERR] = err_flags[ERR_OPTWERR];
                        r.read_data[ST_BSY]     = (busy_left != '0);
                    end
                    OFS_CONTROL: begin
                        r.read_data[CR_PG]              = pg_en;
                        r.read_data[CR_PER]             = per_en;
                        r.read_data[CR_MER]             = mer_en;
                        r.read_data[CR_PNB +: PAGE_BITS] = pnb;
                        r.read_data[CR_BWR]             = bwr_en;
                        r.read_data[CR_STRT]            = strt_en;
                        r.read_data[CR_LOCK]            = lock_q;
                    end
                    default: ;
                endcase
            end
            MODE_WRITE: begin
                case (it.reg_offset)
                    OFS_LATENCY: lat_ws = d[3:0];
                    OFS_KEY: begin
                        if (lock_q) begin
                            if (!key_armed && d == KEY_FIRST) begin
                                key_armed = 1'b1;
                            end else if (key_armed && d == KEY_SECOND) begin
                                lock_q    = 1'b0;
                                key_armed = 1'b0;
                            end else begin
                                key_armed = 1'b0;
                            end
                        end
                    end
                    OFS_STATUS: begin
                        if (d[ST_EOP])     eop = 1'b0;
                        if (d[ST_OPERR])   err_flags[ERR_OPERR]   = 1'b0;
                        if (d[ST_PROGERR]) err_flags[ERR_PROGERR] = 1'b0;
                        if (d[ST_WRPERR])  err_flags[ERR_WRPERR]  = 1'b0;
                        if (d[ST_PGAERR])  err_flags[ERR_PGAERR]  = 1'b0;
                        if (d[ST_SIZERR])  err_flags[ERR_SIZERR]  = 1'b0;
                        if (d[ST_PGSERR])  err_flags[ERR_PGSERR]  = 1'b0;
                        if (d[ST_OPTWERR]) err_flags[ERR_OPTWERR] = 1'b0;
                    end
                    OFS_CONTROL: begin
                        // Locked or busy: drop the whole write.
                        if (!lock_q && busy_left == '0) begin
                            pg_en   = d[CR_PG];
                            per_en  = d[CR_PER];
                            mer_en  = d[CR_MER];
                            bwr_en  = d[CR_BWR];
                            pnb     = d[CR_PNB +: PAGE_BITS];
                            strt_en = 1'b0;
                            if (d[CR_STRT]) begin
                                if (per_en || mer_en) begin
                                    strt_en = 1'b1;
                                    load_busy();
                                end else begin
                                    err_flags[ERR_PGSERR] = 1'b1;
                                end
                            end
                            if (d[CR_LOCK]) begin
                                lock_q    = 1'b1;
                                key_armed = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_TICK: begin
                if (busy_left != '0) begin
                    busy_left = busy_left - 1'b1;
                    if (busy_left == '0) begin
                        eop     = 1'b1;
                        strt_en = 1'b0;
                    end
                end
            end
            default: begin
                // Program request: ignored while busy, else check and start.
                if (busy_left == '0) begin
                    bad = 1'b0;
                    if (!pg_en) begin
                        err_flags[ERR_PGSERR] = 1'b1;
                        bad = 1'b1;
                    end
                    if (it.flash_offset[3:0] != 4'h0) begin
                        err_flags[ERR_PGAERR] = 1'b1;
                        bad = 1'b1;
                    end
                    if (!bad) load_busy();
                end
            end
        endcase
        r.busy_res  = (busy_left != '0);
        r.any_error = (err_flags != '0);
        return r;
    endfunction

    // Watch both channels and the register port at every edge, in one place,
    // so that the order of pushes and pops never depends on the scheduler.
    always @(posedge aclk) begin : watch
        fcr_out_t res;
        fcr_out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) busy_ticks = cfg_data;
            if (s_valid && s_ready) begin
                res = apply_item(s_payload);
                if (drv_fixed) res = drv_fixed_res;
                awaited_results.push_back(res);
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected item: read_data %h busy_res %b any_error %b",
                           m_payload.read_data, m_payload.busy_res, m_payload.any_error);
                    n_fail++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_payload.read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h",
                               want.read_data, m_payload.read_data);
                        n_fail++;
                    end
                    if (m_payload.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %b, got %b",
                               want.busy_res, m_payload.busy_res);
                        n_fail++;
                    end
                    if (m_payload.any_error !== want.any_error) begin
                        $error("any_error: expected %b, got %b",
                               want.any_error, m_payload.any_error);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Receiver: one long hold-off early on to back the pipe up, then short
    // random stalls between runs of steady acceptance; none once calm.
    initial begin : sink
        bit held;
        held = 1'b0;
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!held && n_accepted >= PRESSURE_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        wait (n_cycles >= LIMIT_CYCLES);
        $display("flash_controller_registers test failed");
        $finish;
    end

    function automatic fcr_in_t mk(input fcr_mode_t m, input logic [7:0] ofs,
                                   input logic [31:0] d,
                                   input logic [FLASH_ADDR_BITS-1:0] fa);
        fcr_in_t r;
        r.mode         = m;
        r.reg_offset   = ofs;
        r.write_data   = d;
        r.flash_offset = fa;
        return r;
    endfunction

    function automatic fcr_in_t any_read();
        logic [7:0] ofs;
        case ($urandom_range(0, 4))
            0:       ofs = OFS_LATENCY;
            1:       ofs = OFS_KEY;
            2:       ofs = OFS_STATUS;
            3:       ofs = OFS_CONTROL;
            default: ofs = 8'($urandom);
        endcase
        return mk(MODE_READ, ofs, $urandom, FLASH_ADDR_BITS'($urandom));
    endfunction

    task automatic add_step(input fcr_mode_t m, input logic [7:0] ofs,
                            input logic [31:0] d, input logic [FLASH_ADDR_BITS-1:0] fa,
                            input int unsigned reps, input int unsigned fixed,
                            input logic [31:0] rd, input int unsigned busy,
                            input int unsigned err);
        step_row_t row;
        row.item = mk(m, ofs, d, fa);
        row.reps = 5'(reps);
        row.fixed = 1'(fixed);
        row.res.read_data = rd;
        row.res.busy_res  = 1'(busy);
        row.res.any_error = 1'(err);
        step_table.push_back(row);
    endtask

    // Offer one item and hold it until accepted; then maybe go quiet a while.
    task automatic offer(input fcr_in_t it, input logic fixed, input fcr_out_t res);
        s_payload     <= it;
        s_valid       <= 1'b1;
        drv_fixed     <= fixed;
        drv_fixed_res <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_offered++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every result is back and the pipe is empty.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_busy_ticks(input logic [TICK_BITS-1:0] v);
        settle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic built from short register-level sequences: unlock,
    // erase or program with ticks, flag clearing, latency writes, bare ticks, noise.
    task automatic run_traffic(input int unsigned n_items);
        fcr_in_t     batch[$];
        fcr_in_t     it;
        logic [31:0] d;
        int unsigned n_ticks;
        int unsigned stop_at;
        stop_at = n_offered + n_items;
        while (n_offered < stop_at) begin
            batch = {};
            n_ticks = 0;
            case ($urandom_range(0, 9))
                0, 1: begin
                    batch.push_back(mk(MODE_WRITE, OFS_KEY, KEY_FIRST,
                                       FLASH_ADDR_BITS'($urandom)));
                    batch.push_back(mk(MODE_WRITE, OFS_KEY, KEY_SECOND,
                                       FLASH_ADDR_BITS'($urandom)));
                    // Spoil the sequence now and then.
                    if ($urandom_range(0, 5) == 0)
                        batch[$urandom_range(0, 1)].write_data = $urandom;
                    batch.push_back(mk(MODE_READ, OFS_CONTROL, $urandom,
                                       FLASH_ADDR_BITS'($urandom)));
                end
                2, 3: begin
                    d = $urandom;
                    d[CR_STRT] = ($urandom_range(0, 7) != 0);
                    if ($urandom_range(0, 5) != 0 && !d[CR_PER] && !d[CR_MER])
                        d[CR_PER] = 1'b1;
                    d[CR_LOCK] = ($urandom_range(0, 9) == 0);
                    batch.push_back(mk(MODE_WRITE, OFS_CONTROL, d,
                                       FLASH_ADDR_BITS'($urandom)));
                    n_ticks = $urandom_range(1, 6);
                end
                4, 5: begin
                    d = $urandom;
                    d[CR_PG]   = ($urandom_range(0, 7) != 0);
                    d[CR_STRT] = 1'b0;
                    d[CR_LOCK] = 1'b0;
                    batch.push_back(mk(MODE_WRITE, OFS_CONTROL, d,
                                       FLASH_ADDR_BITS'($urandom)));
                    it = mk(MODE_PROGRAM, 8'($urandom), $urandom,
                            FLASH_ADDR_BITS'($urandom));
                    if ($urandom_range(0, 3) != 0) it.flash_offset[3:0] = 4'h0;
                    batch.push_back(it);
                    n_ticks = $urandom_range(1, 6);
                end
                6: begin
                    batch.push_back(mk(MODE_WRITE, OFS_STATUS, $urandom,
                                       FLASH_ADDR_BITS'($urandom)));
                    batch.push_back(mk(MODE_READ, OFS_STATUS, $urandom,
                                       FLASH_ADDR_BITS'($urandom)));
                end
                7: begin
                    batch.push_back(mk(MODE_WRITE, OFS_LATENCY, $urandom,
                                       FLASH_ADDR_BITS'($urandom)));
                    batch.push_back(any_read());
                end
                8: n_ticks = $urandom_range(1, 20);
                default: begin
                    repeat ($urandom_range(1, 3))
                        batch.push_back(mk(fcr_mode_t'(2'($urandom)), 8'($urandom),
                                           $urandom, FLASH_ADDR_BITS'($urandom)));
                end
            endcase
            // Let the operation run down, with reads mixed in.
            repeat (n_ticks) begin
                if ($urandom_range(0, 2) == 0) batch.push_back(any_read());
                batch.push_back(mk(MODE_TICK, 8'($urandom), $urandom,
                                   FLASH_ADDR_BITS'($urandom)));
            end
            if (n_ticks != 0)
                batch.push_back(mk(MODE_READ, OFS_STATUS, $urandom,
                                   FLASH_ADDR_BITS'($urandom)));
            foreach (batch[i]) offer(batch[i], 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        logic [TICK_BITS-1:0] tick_plan[6];
        s_valid       <= 1'b0;
        s_payload     <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        drv_fixed     <= 1'b0;
        drv_fixed_res <= '0;
        aresetn       <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, run at the reset busy setting. Fixed results are
        // the ones obvious from the register map; the rest go to the mirror.
        add_step(MODE_READ,    OFS_LATENCY, 32'h0, '0, 1, 1, 32'h0, 0, 0);
        add_step(MODE_READ,    OFS_CONTROL, 32'h0, '0, 1, 1, 32'd1 << CR_LOCK, 0, 0);
        // Locked: control write must leave everything as it was.
        add_step(MODE_WRITE,   OFS_CONTROL, 32'hFFFF_FFFF, '0, 1, 1, 32'h0, 0, 0);
        // Latency is taken even while locked.
        add_step(MODE_WRITE,   OFS_LATENCY, 32'hFFFF_FFFF, '0, 1, 1, 32'h0, 0, 0);
        add_step(MODE_READ,    OFS_LATENCY, 32'h0, '0, 1, 1, 32'hF, 0, 0);
        // Broken key sequence, then the second key on its own.
        add_step(MODE_WRITE,   OFS_KEY, KEY_FIRST, '0, 1, 1, 32'h0, 0, 0);
        add_step(MODE_WRITE,   OFS_KEY, 32'h0, '0, 1, 1, 32'h0, 0, 0);
        add_step(MODE_WRITE,   OFS_KEY, KEY_SECOND, '0, 1, 1, 32'h0, 0, 0);
        // Proper unlock.
        add_step(MODE_WRITE,   OFS_KEY, KEY_FIRST, '0, 1, 0, '0, 0, 0);
        add_step(MODE_WRITE,   OFS_KEY, KEY_SECOND, '0, 1, 0, '0, 0, 0);
        add_step(MODE_READ,    OFS_CONTROL, 32'h0, '0, 1, 1, 32'h0, 0, 0);
        // Key write while unlocked is dropped.
        add_step(MODE_WRITE,   OFS_KEY, KEY_FIRST, '0, 1, 0, '0, 0, 0);
        // Start with no erase selected: sequence error.
        add_step(MODE_WRITE,   OFS_CONTROL, 32'd1 << CR_STRT, '0, 1, 1, 32'h0, 0, 1);
        add_step(MODE_READ,    OFS_STATUS, 32'h0, '0, 1, 1, 32'd1 << ST_PGSERR, 0, 1);
        // Program with PG off and a misaligned offset.
        add_step(MODE_PROGRAM, OFS_LATENCY, 32'h0, 20'h00007, 1, 0, '0, 0, 0);
        add_step(MODE_WRITE,   OFS_STATUS, 32'hFFFF_FFFF, '0, 1, 1, 32'h0, 0, 0);
        // PG, full page number and burst, then a good program at the top.
        add_step(MODE_WRITE,   OFS_CONTROL,
                 (32'd1 << CR_PG) | (32'h7F << CR_PNB) | (32'd1 << CR_BWR),
                 '0, 1, 0, '0, 0, 0);
        add_step(MODE_PROGRAM, OFS_LATENCY, 32'h0, 20'hFFFF0, 1, 1, 32'h0, 1, 0);
        // While busy: program and control writes are dropped.
        add_step(MODE_PROGRAM, OFS_LATENCY, 32'h0, 20'h12345, 1, 0, '0, 0, 0);
        add_step(MODE_WRITE,   OFS_CONTROL, (32'd1 << CR_PER) | (32'd1 << CR_STRT),
                 '0, 1, 0, '0, 0, 0);
        add_step(MODE_READ,    8'hFF, 32'h0, '0, 1, 0, '0, 0, 0);
        add_step(MODE_TICK,    OFS_LATENCY, 32'h0, '0, 16, 0, '0, 0, 0);
        // Mass erase with lock set in the same write.
        add_step(MODE_WRITE,   OFS_CONTROL,
                 (32'd1 << CR_MER) | (32'd1 << CR_STRT) | (32'd1 << CR_LOCK),
                 '0, 1, 0, '0, 0, 0);
        add_step(MODE_READ,    OFS_CONTROL, 32'h0, '0, 1, 0, '0, 0, 0);
        add_step(MODE_TICK,    OFS_LATENCY, 32'h0, '0, 16, 0, '0, 0, 0);
        add_step(MODE_READ,    OFS_STATUS, 32'h0, '0, 1, 0, '0, 0, 0);
        // Extra tick with nothing running does nothing.
        add_step(MODE_TICK,    OFS_LATENCY, 32'h0, '0, 1, 0, '0, 0, 0);

        foreach (step_table[i])
            repeat (step_table[i].reps)
                offer(step_table[i].item, step_table[i].fixed, step_table[i].res);

        run_traffic(PHASE_ITEMS);

        // Busy settings: shortest, longest, zero, then mid values; the last
        // phase runs without any idling on either side.
        tick_plan = '{TICK_BITS'(1), {TICK_BITS{1'b1}}, TICK_BITS'(0), TICK_BITS'(2),
                      TICK_BITS'($urandom_range(1, 12)), TICK_BITS'(3)};
        foreach (tick_plan[i]) begin
            set_busy_ticks(tick_plan[i]);
            if (i == 5) calm = 1'b1;
            run_traffic(PHASE_ITEMS);
        end

        settle();
        if (n_fail == 0) begin
            $display("flash_controller_registers test passed");
        end else begin
            $display("flash_controller_registers test failed");
        end
        $finish;
    end

endmodule
